[hdl/ptc_pkg.sv]
`default_nettype none

package ptc_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_TEMP_CAL    = 3'd0;
   localparam logic [2:0] CSR_PRESS_CAL_A = 3'd1;
   localparam logic [2:0] CSR_PRESS_CAL_B = 3'd2;
   localparam logic [2:0] CSR_PRESS_CAL_C = 3'd3;
   localparam logic [2:0] CSR_SEA_LEVEL   = 3'd4;

   localparam logic [16:0] SEA_LEVEL_RESET = 17'd101325;

   localparam int QUEUE_DEPTH = 4;
   localparam int DIV_STAGES  = 64;

   // Fixed-point constants of the compensation.
   localparam longint TFINE_OFFSET = 128000;
   localparam longint PRESS_FULL   = 1048576;
   localparam longint PRESS_SCALE  = 3125;
   localparam longint HPA_ROUND    = 50;
   localparam longint HPA_DEN      = 100;
   localparam longint ALT_NUM      = 843;
   localparam longint ALT_DEN      = 10000;
   localparam longint ALT_SQ_DEN   = 15000;
   localparam longint ALT_SQ_MIN   = 100;

   // Reciprocals, rounded up, exact over the operand ranges that reach them.
   localparam int     HPA_SHIFT    = 26;
   localparam longint HPA_RECIP    = ((64'd1 << HPA_SHIFT) + HPA_DEN - 1) / HPA_DEN;
   localparam int     ALT_SHIFT    = 42;
   localparam longint ALT_RECIP    = ((64'd1 << ALT_SHIFT) + ALT_DEN - 1) / ALT_DEN;
   localparam int     ALT_SQ_SHIFT = 43;
   localparam longint ALT_SQ_RECIP = ((64'd1 << ALT_SQ_SHIFT) + ALT_SQ_DEN - 1) / ALT_SQ_DEN;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
      logic [16:0] sea;
   } cal_type;

   typedef struct packed {
      logic [31:0] tfine;
      logic [19:0] tc;
      logic [19:0] press_sample;
   } queue_entry_type;

   typedef struct packed {
      logic        valid;
      logic [19:0] tc;
      logic [19:0] press_sample;
   } side_type;

   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

endpackage

`default_nettype wire

[hdl/ptc_mul64.sv]
`default_nettype none

// Low 64 bits of a 64 x 64 product, from three 32 x 32 partial products.
// The partial products are registered, and then their sum is registered.
module ptc_mul64 (
   input  logic        clock,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);
   logic [63:0] ll_ff;
   logic [31:0] lh_ff;
   logic [31:0] hl_ff;
   logic [63:0] p_ff;
   logic [31:0] cross_sum;

   assign cross_sum = lh_ff + hl_ff;

   always_ff @(posedge clock) begin
      ll_ff <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
      lh_ff <= a[31:0] * b[63:32];
      hl_ff <= a[63:32] * b[31:0];
      p_ff  <= ll_ff + {cross_sum, 32'd0};
   end

   assign p = p_ff;
endmodule

`default_nettype wire

[hdl/ptc_div.sv]
`default_nettype none

// Signed truncating 64-bit division, one quotient bit per stage.
// The most negative dividend over minus one wraps to itself.
module ptc_div (
   input  logic        clock,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic [63:0] quot,
   output logic        den_zero
);
   import ptc_pkg::*;

   logic [63:0] r_ff    [DIV_STAGES];
   logic [63:0] n_ff    [DIV_STAGES];
   logic [63:0] d_ff    [DIV_STAGES];
   logic        neg_ff  [DIV_STAGES];
   logic        zero_ff [DIV_STAGES];
   logic [63:0] r_in    [DIV_STAGES];
   logic [63:0] n_in    [DIV_STAGES];
   logic [63:0] nmag;
   logic [63:0] dmag;

   assign nmag = num[63] ? 64'd0 - num : num;
   assign dmag = den[63] ? 64'd0 - den : den;

   always_comb begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         logic [63:0] r_prev;
         logic [63:0] n_prev;
         logic [63:0] d_prev;
         logic [64:0] trial;
         r_prev = (j == 0) ? 64'd0 : r_ff[(j == 0) ? 0 : j - 1];
         n_prev = (j == 0) ? nmag  : n_ff[(j == 0) ? 0 : j - 1];
         d_prev = (j == 0) ? dmag  : d_ff[(j == 0) ? 0 : j - 1];
         trial  = {r_prev, n_prev[63]} - {1'b0, d_prev};
         r_in[j] = trial[64] ? {r_prev[62:0], n_prev[63]} : trial[63:0];
         n_in[j] = {n_prev[62:0], ~trial[64]};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         r_ff[j] <= r_in[j];
         n_ff[j] <= n_in[j];
      end
      d_ff[0]    <= dmag;
      neg_ff[0]  <= num[63] ^ den[63];
      zero_ff[0] <= (den == 64'd0);
      for (int j = 1; j < DIV_STAGES; j++) begin
         d_ff[j]    <= d_ff[j-1];
         neg_ff[j]  <= neg_ff[j-1];
         zero_ff[j] <= zero_ff[j-1];
      end
   end

   assign quot     = neg_ff[DIV_STAGES-1] ? 64'd0 - n_ff[DIV_STAGES-1] : n_ff[DIV_STAGES-1];
   assign den_zero = zero_ff[DIV_STAGES-1];
endmodule

`default_nettype wire

[hdl/ptc_front.sv]
`default_nettype none

// Temperature compensation, four stages, advancing together when enabled.
module ptc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  logic [19:0]              temp_sample,
   input  logic [19:0]              press_sample,
   input  ptc_pkg::cal_type         cal,
   output logic                     push,
   output ptc_pkg::queue_entry_type push_data
);
   import ptc_pkg::*;

   logic        v0_ff, v1_ff, v2_ff, v3_ff;
   logic [19:0] rt0_ff;
   logic [19:0] rp0_ff, rp1_ff, rp2_ff, rp3_ff;
   logic [31:0] m1_ff, bb_ff, v1c_ff, x_ff, tfine_ff;
   logic [31:0] a_d, b_d, m1_in, bb_in, v1c_in, x_in, tfine_in;
   logic [31:0] t2x, t3x, t5, tcw;
   logic [19:0] tc_sat;

   assign t2x = {{16{cal.t2[15]}}, cal.t2};
   assign t3x = {{16{cal.t3[15]}}, cal.t3};

   always_comb begin
      a_d      = {15'd0, rt0_ff[19:3]} - {15'd0, cal.t1, 1'b0};
      b_d      = {16'd0, rt0_ff[19:4]} - {16'd0, cal.t1};
      m1_in    = a_d * t2x;
      bb_in    = b_d * b_d;
      v1c_in   = 32'($signed(m1_ff) >>> 11);
      x_in     = 32'($signed(bb_ff) >>> 12) * t3x;
      tfine_in = v1c_ff + 32'($signed(x_ff) >>> 14);
      t5       = (tfine_ff << 2) + tfine_ff + 32'd128;
      tcw      = 32'($signed(t5) >>> 8);
      if ($signed(tcw) > $signed(32'sd524287)) begin
         tc_sat = 20'h7FFFF;
      end else if ($signed(tcw) < $signed(-32'sd524288)) begin
         tc_sat = 20'h80000;
      end else begin
         tc_sat = tcw[19:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rt0_ff   <= temp_sample;
         rp0_ff   <= press_sample;
         rp1_ff   <= rp0_ff;
         rp2_ff   <= rp1_ff;
         rp3_ff   <= rp2_ff;
         m1_ff    <= m1_in;
         bb_ff    <= bb_in;
         v1c_ff   <= v1c_in;
         x_ff     <= x_in;
         tfine_ff <= tfine_in;
      end
   end

   assign push                   = v3_ff && enable;
   assign push_data.tfine        = tfine_ff;
   assign push_data.tc           = tc_sat;
   assign push_data.press_sample = rp3_ff;
endmodule

`default_nettype wire

[hdl/ptc_queue.sv]
`default_nettype none

// Small first-in first-out queue between the temperature and pressure parts.
module ptc_queue #(
   parameter int DEPTH = ptc_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ptc_pkg::queue_entry_type push_data,
   input  logic                     pop,
   output ptc_pkg::queue_entry_type head,
   output logic                     empty,
   output logic                     full
);
   import ptc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign empty   = (count_ff == CNT_W'(0));
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

`default_nettype wire

[hdl/ptc_back.sv]
`default_nettype none

// Pressure compensation, pressure in hPa and altitude; a fixed pipeline that never stalls.
module ptc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  ptc_pkg::queue_entry_type head,
   input  ptc_pkg::cal_type         cal,
   output logic                     out_strobe,
   output logic [19:0]              out_temp_centideg,
   output logic [17:0]              out_press_pascal,
   output logic [11:0]              out_press_hectopascal,
   output logic [15:0]              out_altitude
);
   import ptc_pkg::*;

   localparam int ST_PRE = 5;
   localparam int ST_OUT = 84;
   localparam int SIDE_LEN = ST_OUT + 1;

   side_type    side_ff [SIDE_LEN];
   side_type    side_in;

   logic [63:0] w1_ff, w1_in;
   logic [63:0] sq, w1p5, w1p2, mul_a, mul_d, mul_f, mul_num;
   logic [63:0] bc_ff, bc2_ff, e_ff, e2_ff;
   logic [63:0] w2_ff, w1x_ff, pre_ff, den_ff, pre_in, pdiff;
   logic [63:0] quot, q_ff, ph, ph1_ff, ph2_ff;
   logic        den_zero, z_ff;
   logic [63:0] qd_ff [4];
   logic        zd_ff [5];
   logic [63:0] m9a, m9b, m8, c2a_ff, c2b_ff, sum_ff, p_w, pv;
   logic [17:0] pa_ff, pa_in;
   logic [17:0] pad_ff [5];
   logic [18:0] hsum;
   logic [38:0] hprod;
   logic [11:0] hpa_ff;
   logic [11:0] hpd_ff [4];
   logic signed [18:0] diff;
   logic signed [29:0] d843_ff, d843_in;
   logic [27:0] amag;
   logic [56:0] aprod;
   logic [14:0] altm_ff;
   logic        aneg_ff;
   logic signed [15:0] alt_ff, alt1_ff, alt2_ff, alt_in, alt_out;
   logic [31:0] asq_full;
   logic [28:0] asq_ff;
   logic [58:0] bprod;
   logic [14:0] bonus_ff;
   logic        strobe_ff;
   logic [19:0] tc_ff;
   logic [17:0] pa_out_ff;
   logic [11:0] hpa_out_ff;
   logic [15:0] alt_out_ff;

   assign side_in = '{valid: head_valid, tc: head.tc, press_sample: head.press_sample};
   assign w1_in   = {{32{head.tfine[31]}}, head.tfine} - 64'(TFINE_OFFSET);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SIDE_LEN; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else begin
         side_ff[0] <= side_in;
         for (int k = 1; k < SIDE_LEN; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Temperature-dependent pressure terms.
   ptc_mul64 u_sq   (.clock(clock), .a(w1_ff), .b(w1_ff),         .p(sq));
   ptc_mul64 u_w1p5 (.clock(clock), .a(w1_ff), .b(sx16(cal.p5)),  .p(w1p5));
   ptc_mul64 u_w1p2 (.clock(clock), .a(w1_ff), .b(sx16(cal.p2)),  .p(w1p2));
   ptc_mul64 u_a    (.clock(clock), .a(sq),    .b(sx16(cal.p6)),  .p(mul_a));
   ptc_mul64 u_d    (.clock(clock), .a(sq),    .b(sx16(cal.p3)),  .p(mul_d));
   ptc_mul64 u_f    (.clock(clock), .a(w1x_ff), .b({48'd0, cal.p1}), .p(mul_f));
   ptc_mul64 u_num  (.clock(clock), .a(pre_ff), .b(64'(PRESS_SCALE)), .p(mul_num));

   assign pdiff  = 64'(PRESS_FULL) - {44'd0, side_ff[ST_PRE].press_sample};
   assign pre_in = (pdiff << 31) - w2_ff;

   ptc_div u_div (.clock(clock), .num(mul_num), .den(den_ff), .quot(quot),
                  .den_zero(den_zero));

   // Corrections after the division.
   assign ph = 64'($signed(q_ff) >>> 13);
   ptc_mul64 u_m9a (.clock(clock), .a(sx16(cal.p9)), .b(ph),     .p(m9a));
   ptc_mul64 u_m8  (.clock(clock), .a(sx16(cal.p8)), .b(q_ff),   .p(m8));
   ptc_mul64 u_m9b (.clock(clock), .a(m9a),          .b(ph2_ff), .p(m9b));

   always_comb begin
      p_w = 64'($signed(sum_ff) >>> 8) + (sx16(cal.p7) << 4);
      pv  = 64'($signed(p_w) >>> 8);
      if (zd_ff[4] || $signed(pv) < $signed(64'sd0)) begin
         pa_in = 18'd0;
      end else if ($signed(pv) > $signed(64'sd262143)) begin
         pa_in = 18'h3FFFF;
      end else begin
         pa_in = pv[17:0];
      end
      hsum    = {1'b0, pa_ff} + 19'(HPA_ROUND);
      hprod   = {20'd0, hsum} * 39'(HPA_RECIP);
      diff    = $signed({2'b00, cal.sea}) - $signed({1'b0, pa_ff});
      d843_in = 30'(diff) * 30'(ALT_NUM);
      amag    = 28'(d843_ff[29] ? -d843_ff : d843_ff);
      aprod   = {29'd0, amag} * 57'(ALT_RECIP);
      alt_in  = aneg_ff ? -$signed({1'b0, altm_ff}) : $signed({1'b0, altm_ff});
      asq_full = 32'(alt_ff) * 32'(alt_ff);
      bprod   = {30'd0, asq_ff} * 59'(ALT_SQ_RECIP);
      alt_out = (alt2_ff > $signed(16'(ALT_SQ_MIN))) ? alt2_ff + $signed({1'b0, bonus_ff})
                                                      : alt2_ff;
   end

   always_ff @(posedge clock) begin
      w1_ff  <= w1_in;
      bc_ff  <= (w1p5 << 17) + (sx16(cal.p4) << 35);
      e_ff   <= w1p2 << 12;
      bc2_ff <= bc_ff;
      e2_ff  <= e_ff;
      w2_ff  <= mul_a + bc2_ff;
      w1x_ff <= 64'h0000_8000_0000_0000 + 64'($signed(mul_d) >>> 8) + e2_ff;
      pre_ff <= pre_in;
      den_ff <= 64'($signed(mul_f) >>> 33);
      q_ff   <= quot;
      z_ff   <= den_zero;
      ph1_ff <= ph;
      ph2_ff <= ph1_ff;
      qd_ff[0] <= q_ff;
      zd_ff[0] <= z_ff;
      for (int k = 1; k < 4; k++) begin
         qd_ff[k] <= qd_ff[k-1];
      end
      for (int k = 1; k < 5; k++) begin
         zd_ff[k] <= zd_ff[k-1];
      end
      c2a_ff  <= 64'($signed(m8) >>> 19);
      c2b_ff  <= c2a_ff;
      sum_ff  <= qd_ff[3] + 64'($signed(m9b) >>> 25) + c2b_ff;
      pa_ff   <= pa_in;
      hpa_ff  <= hprod[37:26];
      d843_ff <= d843_in;
      pad_ff[0] <= pa_ff;
      for (int k = 1; k < 5; k++) begin
         pad_ff[k] <= pad_ff[k-1];
      end
      hpd_ff[0] <= hpa_ff;
      for (int k = 1; k < 4; k++) begin
         hpd_ff[k] <= hpd_ff[k-1];
      end
      altm_ff  <= aprod[56:42];
      aneg_ff  <= d843_ff[29];
      alt_ff   <= alt_in;
      asq_ff   <= asq_full[28:0];
      alt1_ff  <= alt_ff;
      bonus_ff <= bprod[57:43];
      alt2_ff  <= alt1_ff;
      tc_ff      <= side_ff[ST_OUT].tc;
      pa_out_ff  <= pad_ff[4];
      hpa_out_ff <= hpd_ff[3];
      alt_out_ff <= alt_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= side_ff[ST_OUT].valid;
      end
   end

   assign out_strobe            = strobe_ff;
   assign out_temp_centideg     = tc_ff;
   assign out_press_pascal      = pa_out_ff;
   assign out_press_hectopascal = hpa_out_ff;
   assign out_altitude          = alt_out_ff;
endmodule

`default_nettype wire

[hdl/pressure_temperature_compensation.sv]
`default_nettype none

// Channel        Ports                                           Handshake
// request        start, busy, req_temp_sample, req_press_sample  beat when start and not busy
// response       rsp_strobe, rsp_temp_centideg, ...              one beat per strobe cycle
// configuration  csr_we, csr_index, csr_wdata                    write when csr_we
//
// A new request beat can be taken in every cycle. The strobe of its response beat comes
// after the beat has passed the front end, the queue and the pressure path with its 64-stage
// pipelined divider and pipelined 64-bit multipliers.
// Reset is synchronous: it empties the pipeline and the queue and loads the
// calibration registers with their reset values (sea level 101325 Pa, others zero).
// The response side cannot stall; the pressure part drains one entry per cycle, so busy stays low.
module pressure_temperature_compensation #(
   parameter int QUEUE_DEPTH = ptc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [19:0] req_temp_sample,
   input  logic [19:0] req_press_sample,
   output logic        rsp_strobe,
   output logic signed [19:0] rsp_temp_centideg,
   output logic [17:0] rsp_press_pascal,
   output logic [11:0] rsp_press_hectopascal,
   output logic signed [15:0] rsp_altitude,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import ptc_pkg::*;

   // Calibration registers, to be written only while no beat is in flight; the block does not enforce this.
   logic [47:0] temp_cal_ff;
   logic [63:0] press_cal_a_ff;
   logic [63:0] press_cal_b_ff;
   logic [15:0] press_cal_c_ff;
   logic [16:0] sea_level_ff;

   cal_type         cal;
   queue_entry_type push_data, head;
   logic            push, empty, full;
   logic [19:0]     tc_w;
   logic [15:0]     alt_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff    <= '0;
         press_cal_a_ff <= '0;
         press_cal_b_ff <= '0;
         press_cal_c_ff <= '0;
         sea_level_ff   <= SEA_LEVEL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEMP_CAL:    temp_cal_ff    <= csr_wdata[47:0];
            CSR_PRESS_CAL_A: press_cal_a_ff <= csr_wdata;
            CSR_PRESS_CAL_B: press_cal_b_ff <= csr_wdata;
            CSR_PRESS_CAL_C: press_cal_c_ff <= csr_wdata[15:0];
            CSR_SEA_LEVEL:   sea_level_ff   <= csr_wdata[16:0];
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   // Unpack the calibration words into named fields.
   assign cal.t1  = temp_cal_ff[15:0];
   assign cal.t2  = temp_cal_ff[31:16];
   assign cal.t3  = temp_cal_ff[47:32];
   assign cal.p1  = press_cal_a_ff[15:0];
   assign cal.p2  = press_cal_a_ff[31:16];
   assign cal.p3  = press_cal_a_ff[47:32];
   assign cal.p4  = press_cal_a_ff[63:48];
   assign cal.p5  = press_cal_b_ff[15:0];
   assign cal.p6  = press_cal_b_ff[31:16];
   assign cal.p7  = press_cal_b_ff[47:32];
   assign cal.p8  = press_cal_b_ff[63:48];
   assign cal.p9  = press_cal_c_ff;
   assign cal.sea = sea_level_ff;

   // The front end holds while the queue is full, so busy follows the queue.
   assign busy = full;

   ptc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .enable       (!full),
      .in_valid     (start && !busy),
      .temp_sample  (req_temp_sample),
      .press_sample (req_press_sample),
      .cal          (cal),
      .push         (push),
      .push_data    (push_data)
   );

   ptc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (!empty),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   // The back end takes the head entry in every cycle the queue holds one.
   ptc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_valid            (!empty),
      .head                  (head),
      .cal                   (cal),
      .out_strobe            (rsp_strobe),
      .out_temp_centideg     (tc_w),
      .out_press_pascal      (rsp_press_pascal),
      .out_press_hectopascal (rsp_press_hectopascal),
      .out_altitude          (alt_w)
   );

   assign rsp_temp_centideg = $signed(tc_w);
   assign rsp_altitude      = $signed(alt_w);
endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

import ptc_pkg::*;

typedef struct {
   logic signed [19:0] temp_centideg;
   logic [17:0]        press_pascal;
   logic [11:0]        press_hectopascal;
   logic signed [15:0] altitude;
} compensated_reading_type;

// Keeps a private copy of the calibration registers, works out the compensated
// reading for every accepted request beat and checks response beats in order.
class compensation_scoreboard;
   logic [47:0] temp_cal;
   logic [63:0] press_cal_a;
   logic [63:0] press_cal_b;
   logic [15:0] press_cal_c;
   logic [16:0] sea_level;
   compensated_reading_type pending_readings[$];
   int failures;
   int checked;

   function new();
      temp_cal    = '0;
      press_cal_a = '0;
      press_cal_b = '0;
      press_cal_c = '0;
      sea_level   = SEA_LEVEL_RESET;
      failures    = 0;
      checked     = 0;
   endfunction

   function void write_reg(logic [2:0] index, logic [63:0] data);
      case (index)
         CSR_TEMP_CAL:    temp_cal    = data[47:0];
         CSR_PRESS_CAL_A: press_cal_a = data;
         CSR_PRESS_CAL_B: press_cal_b = data;
         CSR_PRESS_CAL_C: press_cal_c = data[15:0];
         CSR_SEA_LEVEL:   sea_level   = data[16:0];
         default: ;
      endcase
   endfunction

   function compensated_reading_type compensate(logic [19:0] temp_sample,
                                                logic [19:0] press_sample);
      int t1, t2, t3, a, b, v1, v2, tfine, tc;
      longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint w1, w2, p, num, q, ph, c1, c2, pa, diff, alt;
      compensated_reading_type r;
      // Temperature path, wrapping at 32 bits.
      t1 = {16'd0, temp_cal[15:0]};
      t2 = int'($signed(temp_cal[31:16]));
      t3 = int'($signed(temp_cal[47:32]));
      a = (temp_sample >> 3) - (t1 << 1);
      v1 = a * t2;
      v1 = v1 >>> 11;
      b = (temp_sample >> 4) - t1;
      v2 = b * b;
      v2 = v2 >>> 12;
      v2 = v2 * t3;
      v2 = v2 >>> 14;
      tfine = v1 + v2;
      tc = tfine * 5 + 128;
      tc = tc >>> 8;
      r.temp_centideg = 20'((tc > 524287) ? 524287 : ((tc < -524288) ? -524288 : tc));
      // Pressure path, wrapping at 64 bits.
      p1 = {48'd0, press_cal_a[15:0]};
      p2 = longint'($signed(press_cal_a[31:16]));
      p3 = longint'($signed(press_cal_a[47:32]));
      p4 = longint'($signed(press_cal_a[63:48]));
      p5 = longint'($signed(press_cal_b[15:0]));
      p6 = longint'($signed(press_cal_b[31:16]));
      p7 = longint'($signed(press_cal_b[47:32]));
      p8 = longint'($signed(press_cal_b[63:48]));
      p9 = longint'($signed(press_cal_c));
      w1 = longint'(tfine);
      w1 = w1 - 128000;
      w2 = w1 * w1 * p6 + ((w1 * p5) <<< 17) + (p4 <<< 35);
      w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) <<< 12);
      w1 = (((longint'(1) <<< 47) + w1) * p1) >>> 33;
      pa = 0;
      // A zero divisor leaves the pressure at zero.
      if (w1 != 0) begin
         p = {44'd0, press_sample};
         p = 1048576 - p;
         num = ((p <<< 31) - w2) * 3125;
         // Dividing by minus one is a negation, which wraps for the most negative value.
         if (w1 == -1) begin
            q = -num;
         end else begin
            q = num / w1;
         end
         ph = q >>> 13;
         c1 = (p9 * ph * ph) >>> 25;
         c2 = (p8 * q) >>> 19;
         p = ((q + c1 + c2) >>> 8) + (p7 <<< 4);
         p = p >>> 8;
         pa = (p < 0) ? 0 : ((p > 262143) ? 262143 : p);
      end
      r.press_pascal = 18'(pa);
      r.press_hectopascal = 12'((pa + 50) / 100);
      diff = {47'd0, sea_level};
      diff = diff - pa;
      alt = (diff * 843) / 10000;
      if (alt > 100) begin
         alt = alt + (alt * alt) / 15000;
      end
      r.altitude = 16'((alt > 32767) ? 32767 : ((alt < -32768) ? -32768 : alt));
      return r;
   endfunction

   function void note_reading(logic [19:0] temp_sample, logic [19:0] press_sample);
      pending_readings.push_back(compensate(temp_sample, press_sample));
   endfunction

   function void check_result(logic signed [19:0] tc, logic [17:0] pa,
                              logic [11:0] hpa, logic signed [15:0] alt);
      compensated_reading_type e;
      if (pending_readings.size() == 0) begin
         $error("response beat with no request outstanding");
         failures++;
         return;
      end
      e = pending_readings.pop_front();
      checked++;
      if (tc !== e.temp_centideg) begin
         $error("temp_centideg expected %0d actual %0d", e.temp_centideg, tc);
         failures++;
      end
      if (pa !== e.press_pascal) begin
         $error("press_pascal expected %0d actual %0d", e.press_pascal, pa);
         failures++;
      end
      if (hpa !== e.press_hectopascal) begin
         $error("press_hectopascal expected %0d actual %0d", e.press_hectopascal, hpa);
         failures++;
      end
      if (alt !== e.altitude) begin
         $error("altitude expected %0d actual %0d", e.altitude, alt);
         failures++;
      end
   endfunction
endclass

module tb_top;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [19:0] req_temp_sample = '0;
   logic [19:0] req_press_sample = '0;
   logic        rsp_strobe;
   logic signed [19:0] rsp_temp_centideg;
   logic [17:0] rsp_press_pascal;
   logic [11:0] rsp_press_hectopascal;
   logic signed [15:0] rsp_altitude;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // When set, the sender never inserts idle cycles between request beats.
   bit back_to_back = 1'b0;
   int beats_sent = 0;
   int cal_sets = 0;

   compensation_scoreboard readings = new();

   pressure_temperature_compensation dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_temp_sample(req_temp_sample),
      .req_press_sample(req_press_sample),
      .rsp_strobe(rsp_strobe),
      .rsp_temp_centideg(rsp_temp_centideg),
      .rsp_press_pascal(rsp_press_pascal),
      .rsp_press_hectopascal(rsp_press_hectopascal),
      .rsp_altitude(rsp_altitude),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Both monitors run at the rising edge and see the values from before the edge,
   // since the block updates its outputs with nonblocking assignments and the bench
   // drives its inputs at the falling edge.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         readings.note_reading(req_temp_sample, req_press_sample);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         readings.check_result(rsp_temp_centideg, rsp_press_pascal,
                               rsp_press_hectopascal, rsp_altitude);
      end
   end

   // Presents one request beat; entered and left at a falling edge. The start line
   // stays high when beats follow each other without an idle cycle.
   task automatic send_reading(logic [19:0] temp_sample, logic [19:0] press_sample);
      if (!back_to_back) begin
         while ($urandom_range(99) < 25) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start <= 1'b1;
      req_temp_sample <= temp_sample;
      req_press_sample <= press_sample;
      do begin
         @(posedge clock);
      end while (busy);
      beats_sent++;
      @(negedge clock);
   endtask

   // Lowers start and waits until every outstanding reading has come back, then lets
   // the pipeline latency pass once more so the block is fully idle.
   task automatic drain_pipeline();
      start <= 1'b0;
      while (readings.pending_readings.size() != 0) begin
         @(negedge clock);
      end
      repeat (100) @(negedge clock);
   endtask

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic write_csr(logic [2:0] index, logic [63:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      readings.write_reg(index, data);
      @(negedge clock);
   endtask

   task automatic load_calibration(logic [47:0] t_cal, logic [63:0] p_cal_a,
                                   logic [63:0] p_cal_b, logic [15:0] p_cal_c,
                                   logic [16:0] sea);
      drain_pipeline();
      write_csr(CSR_TEMP_CAL, {16'd0, t_cal});
      write_csr(CSR_PRESS_CAL_A, p_cal_a);
      write_csr(CSR_PRESS_CAL_B, p_cal_b);
      write_csr(CSR_PRESS_CAL_C, {48'd0, p_cal_c});
      write_csr(CSR_SEA_LEVEL, {47'd0, sea});
      csr_we <= 1'b0;
      cal_sets++;
      @(negedge clock);
   endtask

   // Mostly readings in the range a real sensor produces, with some over the full
   // 20-bit span so every input bit toggles.
   task automatic send_random(int count);
      logic [19:0] rt, rp;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 75) begin
            rt = 20'($urandom_range(600000, 400000));
            rp = 20'($urandom_range(500000, 250000));
         end else begin
            rt = 20'($urandom);
            rp = 20'($urandom);
         end
         send_reading(rt, rp);
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset calibration: every word is zero, so the pressure divisor is zero and
      // the pressure comes out as 0 Pa with the altitude from the reset sea level.
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'd519888, 20'd415148);
      send_random(5);

      // A typical factory calibration.
      load_calibration({16'hFC18, 16'd26435, 16'd27504},
                       {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                       {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                       16'd6000, SEA_LEVEL_RESET);
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'd0);
      send_reading(20'd0, 20'hFFFFF);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'd519888, 20'd415148);
      send_reading(20'd519888, 20'd1);
      send_reading(20'd519888, 20'hFFFFF);
      send_reading(20'd1, 20'd415148);
      send_reading(20'h80000, 20'h80000);
      send_reading(20'h7FFFF, 20'h7FFFF);
      send_reading(20'd440000, 20'd600000);
      send_reading(20'd600000, 20'd200000);
      back_to_back = 1'b1;
      send_random(80);
      back_to_back = 1'b0;
      send_random(60);
      // The sender holds off here until every reading is back.
      drain_pipeline();
      send_random(100);

      // A random calibration with the lowest sea level of the stated range.
      load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                       {$urandom, $urandom}, 16'($urandom), 17'd30000);
      send_random(40);

      // All words at all ones and the highest sea level.
      load_calibration('1, '1, '1, 16'hFFFF, 17'h1FFFF);
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_random(30);

      // Signed words at their most negative and most positive, sea level zero.
      load_calibration({16'h8000, 16'h7FFF, 16'hFFFF},
                       {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
                       {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
                       16'h8000, 17'd0);
      send_random(30);
      load_calibration({16'h7FFF, 16'h8000, 16'h0001},
                       {16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001},
                       {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                       16'h7FFF, 17'd101325);
      send_random(30);

      load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                       {$urandom, $urandom}, 16'($urandom),
                       17'($urandom_range(131071, 30000)));
      send_random(40);

      drain_pipeline();
      $display("Sent %0d request beats over %0d calibration sets plus reset values,",
               beats_sent, cal_sets);
      $display("checked %0d response beats with %0d field mismatches.",
               readings.checked, readings.failures);
      if (readings.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
